// ===== src/cdqb_pkg.sv =====
// Shared types and constants for the circular deque buffer.
`default_nettype none
package cdqb_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W  = IDX_W + 1;
   localparam int unsigned CAP_W  = 5;
   localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CMD_W  = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] EMPTY_ITEM = '1;

   localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

endpackage
`default_nettype wire

// ===== src/circular_deque_buffer_unit.sv =====
// Circular deque buffer: ring store, head/count pointers and response register.
// Sequence: the pointer update and write, the synchronous two-port read of front and
//   rear, and the response load run in turn; the load waits while rsp_stall holds a
//   valid response, and req_stall refuses a new transaction until the load is done.
// Reset: synchronous, active high; head and count clear, capacity returns to 16,
//   ring store contents are left as they are (unwritten slots are never presented).
`default_nettype none
module circular_deque_buffer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [cdqb_pkg::CMD_W-1:0]           req_command,
   input  wire  signed [cdqb_pkg::DATA_W-1:0]   req_item_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [cdqb_pkg::DATA_W-1:0]   rsp_front_item,
   output logic signed [cdqb_pkg::DATA_W-1:0]   rsp_rear_item,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full,
   input  wire                                  csr_wr_en,
   input  wire  [cdqb_pkg::CAP_W-1:0]           csr_wr_data
);

   localparam int unsigned IDX_W  = cdqb_pkg::IDX_W;
   localparam int unsigned CNT_W  = cdqb_pkg::CNT_W;
   localparam int unsigned SUM_W  = cdqb_pkg::SUM_W;
   localparam int unsigned CMP_W  = cdqb_pkg::CMP_W;
   localparam int unsigned DATA_W = cdqb_pkg::DATA_W;
   localparam int unsigned DEPTH  = cdqb_pkg::DEPTH;

   cdqb_pkg::state_type state_ff, state_in;

   logic [DATA_W-1:0]           ring_store_ff [DEPTH];
   logic [DATA_W-1:0]           rd_front_ff, rd_rear_ff;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [cdqb_pkg::CAP_W-1:0]  capacity_ff;
   logic                        ok_ff, ok_in;

   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff, rsp_empty_ff, rsp_full_ff;
   logic [DATA_W-1:0]           rsp_front_ff, rsp_rear_ff;

   logic                        accept, mem_we, full, empty, rsp_load;
   logic [IDX_W-1:0]            wr_addr, head_inc, head_dec, tail_idx, rear_idx;
   logic [CMP_W-1:0]            cap_ext, eff_cap;
   logic [SUM_W-1:0]            tail_sum, rear_sum;

   // effective capacity: zero acts as one, above DEPTH clamps to DEPTH
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full  = CMP_W'(count_ff) >= eff_cap;
   assign empty = count_ff == '0;

   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(head_ff + 1'b1);
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(head_ff - 1'b1);

   // slot after the rear: head + count, wrapped once
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
   // rear slot; an empty deque reads the head slot and the data is discarded
   assign rear_sum = empty ? SUM_W'(head_ff) : SUM_W'(tail_sum - 1'b1);
   assign rear_idx = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(rear_sum);

   assign req_stall = state_ff != cdqb_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == cdqb_pkg::ST_LOAD) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      mem_we   = 1'b0;
      wr_addr  = tail_idx;
      if (accept) begin
         ok_in = 1'b1;
         case (req_command)
            cdqb_pkg::CMD_INS_FRONT: begin
               if (full) begin
                  ok_in = 1'b0;
               end else begin
                  head_in  = head_dec;
                  wr_addr  = head_dec;
                  mem_we   = 1'b1;
                  count_in = CNT_W'(count_ff + 1'b1);
               end
            end
            cdqb_pkg::CMD_INS_REAR: begin
               if (full) begin
                  ok_in = 1'b0;
               end else begin
                  mem_we   = 1'b1;
                  count_in = CNT_W'(count_ff + 1'b1);
               end
            end
            cdqb_pkg::CMD_DEL_FRONT: begin
               if (empty) begin
                  ok_in = 1'b0;
               end else begin
                  head_in  = head_inc;
                  count_in = CNT_W'(count_ff - 1'b1);
               end
            end
            cdqb_pkg::CMD_DEL_REAR: begin
               if (empty) begin
                  ok_in = 1'b0;
               end else begin
                  count_in = CNT_W'(count_ff - 1'b1);
               end
            end
            default: begin
               // query and unknown codes leave head and count alone and report ok
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdqb_pkg::ST_IDLE: begin
            if (accept) state_in = cdqb_pkg::ST_READ;
         end
         cdqb_pkg::ST_READ: begin
            state_in = cdqb_pkg::ST_LOAD;
         end
         cdqb_pkg::ST_LOAD: begin
            if (rsp_load) state_in = cdqb_pkg::ST_IDLE;
         end
         default: begin
            state_in = cdqb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdqb_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         capacity_ff  <= cdqb_pkg::CAP_RESET;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
         if (csr_wr_en) capacity_ff <= csr_wr_data;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring store: write on an accepted insert that finds room, read both ends in the cycle after
   always_ff @(posedge clock) begin
      if (mem_we) ring_store_ff[wr_addr] <= req_item_value;
   end

   always_ff @(posedge clock) begin
      if (state_ff == cdqb_pkg::ST_READ) begin
         rd_front_ff <= ring_store_ff[head_ff];
         rd_rear_ff  <= ring_store_ff[rear_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_empty_ff <= empty;
         rsp_full_ff  <= full;
         rsp_front_ff <= empty ? cdqb_pkg::EMPTY_ITEM : rd_front_ff;
         rsp_rear_ff  <= empty ? cdqb_pkg::EMPTY_ITEM : rd_rear_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_front_item = rsp_front_ff;
   assign rsp_rear_item  = rsp_rear_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(DEPTH) >= count_ff)
      else $error("item count above depth");

   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdqb_pkg::ST_READ) |=> (state_ff == cdqb_pkg::ST_LOAD))
      else $error("read phase not followed by load");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cdqb_pkg::ST_LOAD))
      else $error("response raised outside load phase");

   a_empty_items: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         (rsp_front_ff == cdqb_pkg::EMPTY_ITEM) && (rsp_rear_ff == cdqb_pkg::EMPTY_ITEM))
      else $error("empty response carries stale items");
`endif

endmodule
`default_nettype wire
